[src/manchester_transmitter_with_pilot_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Manchester transmitter with pilot
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_TRANSMITTER_WITH_PILOT_UNIT_ASSERT_SVH
`define MANCHESTER_TRANSMITTER_WITH_PILOT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define MTP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define MTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MTP_ASSERT(label, clk, rst, prop)
`define MTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/mtp_pkg.sv]
// ----------------------------------------------------------------------------
// mtp_pkg
// Types and constants shared by the Manchester transmitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

   // loader progress
   typedef enum logic [1:0] {
      MODE_DIGITS = 2'd0,
      MODE_BITS   = 2'd1,
      MODE_SEND   = 2'd2
   } mode_type;

   // queued work for the line driver
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_START = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     bit_val;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   // line segments
   localparam logic [1:0] SEG_PILOT = 2'd0;
   localparam logic [1:0] SEG_GAP   = 2'd1;
   localparam logic [1:0] SEG_DATA  = 2'd2;

   // received characters
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_ONE  = 8'd49;
   localparam logic [7:0] CHAR_TWO  = 8'd50;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   localparam logic [1:0] COUNT_DIGITS = 2'd3;

   // configuration registers
   localparam int PILOT_W = 9;
   localparam int GAP_W   = 4;
   localparam int CSR_W   = 9;
   localparam logic [PILOT_W-1:0] PILOT_RESET = 9'd400;
   localparam logic [GAP_W-1:0]   GAP_RESET   = 4'd4;
   localparam logic CSR_PILOT = 1'b0;
   localparam logic CSR_GAP   = 1'b1;

endpackage

`default_nettype wire

[src/mtp_front.sv]
// ----------------------------------------------------------------------------
// mtp_front
// Accepts requests, loads the bit count, and queues store writes, the start
// marker and transmit ticks for the line driver.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_front #(
   parameter int MAX_BITS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          action,
   input  wire logic [7:0]                    rx_char,
   input  wire logic                          q_full,
   output logic                               q_push,
   output mtp_pkg::cmd_type                   q_cmd,
   output logic [$clog2(MAX_BITS)-1:0]        q_addr,
   output logic [$clog2(MAX_BITS+1)-1:0]      message_bits
);

   localparam int CW = $clog2(MAX_BITS + 1);
   localparam int AW = $clog2(MAX_BITS);
   localparam int NW = CW + 4;

   mtp_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        digits_left_ff, digits_left_in;
   logic [CW-1:0]     message_bits_ff, message_bits_in;
   logic [CW-1:0]     write_pos_ff, write_pos_in;
   logic              accept;
   logic [NW-1:0]     count_next;

   assign req_ready    = !q_full;
   assign accept       = req_valid && req_ready;
   assign message_bits = message_bits_ff;

   // times ten plus the new digit
   assign count_next = {message_bits_ff, 3'b000} + {1'b0, message_bits_ff, 1'b0}
                       + NW'(rx_char[3:0]);

   always_comb begin
      mode_in         = mode_ff;
      digits_left_in  = digits_left_ff;
      message_bits_in = message_bits_ff;
      write_pos_in    = write_pos_ff;
      q_push          = 1'b0;
      q_cmd.kind      = mtp_pkg::KIND_TICK;
      q_cmd.bit_val   = rx_char[0];
      q_addr          = write_pos_ff[AW-1:0];
      if (accept) begin
         if (action) begin
            if (mode_ff == mtp_pkg::MODE_SEND) begin
               q_push = 1'b1;
            end
         end else begin
            case (mode_ff)
               mtp_pkg::MODE_DIGITS: begin
                  if (rx_char inside {[mtp_pkg::CHAR_ZERO:mtp_pkg::CHAR_NINE]}) begin
                     message_bits_in = (count_next > NW'(MAX_BITS)) ? CW'(MAX_BITS)
                                                                     : count_next[CW-1:0];
                     if (digits_left_ff != 2'd0) begin
                        digits_left_in = digits_left_ff - 2'd1;
                     end
                     if (digits_left_in == 2'd0) begin
                        mode_in = mtp_pkg::MODE_BITS;
                     end
                  end
               end
               mtp_pkg::MODE_BITS: begin
                  if (rx_char == mtp_pkg::CHAR_ZERO || rx_char == mtp_pkg::CHAR_ONE) begin
                     // drop bits past the store depth
                     if (write_pos_ff < CW'(MAX_BITS)) begin
                        q_push       = 1'b1;
                        q_cmd.kind   = mtp_pkg::KIND_WRITE;
                        write_pos_in = write_pos_ff + CW'(1);
                     end
                  end else if (rx_char == mtp_pkg::CHAR_TWO) begin
                     q_push     = 1'b1;
                     q_cmd.kind = mtp_pkg::KIND_START;
                     mode_in    = mtp_pkg::MODE_SEND;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= mtp_pkg::MODE_DIGITS;
         digits_left_ff  <= mtp_pkg::COUNT_DIGITS;
         message_bits_ff <= '0;
         write_pos_ff    <= '0;
      end else begin
         mode_ff         <= mode_in;
         digits_left_ff  <= digits_left_in;
         message_bits_ff <= message_bits_in;
         write_pos_ff    <= write_pos_in;
      end
   end

endmodule

`default_nettype wire

[src/mtp_queue.sv]
// ----------------------------------------------------------------------------
// mtp_queue
// Two-entry queue between the request front and the line driver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "manchester_transmitter_with_pilot_unit_assert.svh"

module mtp_queue #(
   parameter int DW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [DW-1:0] push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output logic [DW-1:0]      pop_data
);

   logic [DW-1:0] entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MTP_ASSERT(a_no_overflow, clock, reset, !(push && full && !pop))
   `MTP_ASSERT(a_no_underflow, clock, reset, !(pop && !not_empty))
   `MTP_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

`default_nettype wire

[src/mtp_back.sv]
// ----------------------------------------------------------------------------
// mtp_back
// Line driver: holds the bit store, runs pilot, gap and Manchester data,
// and drives the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "manchester_transmitter_with_pilot_unit_assert.svh"

module mtp_back #(
   parameter int MAX_BITS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [mtp_pkg::PILOT_W-1:0]         pilot_ticks,
   input  wire logic [mtp_pkg::GAP_W-1:0]           gap_ticks,
   input  wire logic [$clog2(MAX_BITS+1)-1:0]       message_bits,
   input  wire logic                                q_valid,
   input  wire mtp_pkg::cmd_type                    q_cmd,
   input  wire logic [$clog2(MAX_BITS)-1:0]         q_addr,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     line_level,
   output logic [1:0]                               segment
);

   localparam int CW = $clog2(MAX_BITS + 1);
   localparam int AW = $clog2(MAX_BITS);

   logic                        bit_store [MAX_BITS];
   logic                        rd_data_ff;
   logic                        mem_we;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [mtp_pkg::PILOT_W-1:0] preamble_pos_ff, preamble_pos_in;
   logic [mtp_pkg::GAP_W-1:0]   gap_left_ff, gap_left_in;
   logic                        second_half_ff, second_half_in;
   logic [CW-1:0]               read_pos_ff, read_pos_in;
   logic [CW-1:0]               read_pos_inc;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        level_ff, level_in;
   logic [1:0]                  seg_ff, seg_in;
   logic                        out_free;
   logic                        cur_bit;
   logic                        tick_pop;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign q_pop        = q_valid && (q_cmd.kind != mtp_pkg::KIND_TICK || out_free);
   assign tick_pop     = q_pop && (q_cmd.kind == mtp_pkg::KIND_TICK);
   assign rsp_valid    = rsp_valid_ff;
   assign line_level   = level_ff;
   assign segment      = seg_ff;
   // entries at or past the fill count were never written and read as zero
   assign cur_bit      = rd_data_ff && (read_pos_ff < fill_ff);
   assign read_pos_inc = read_pos_ff + CW'(1);

   always_comb begin
      mem_we          = 1'b0;
      fill_in         = fill_ff;
      preamble_pos_in = preamble_pos_ff;
      gap_left_in     = gap_left_ff;
      second_half_in  = second_half_ff;
      read_pos_in     = read_pos_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      level_in        = level_ff;
      seg_in          = seg_ff;
      if (q_pop) begin
         case (q_cmd.kind)
            mtp_pkg::KIND_WRITE: begin
               mem_we  = 1'b1;
               fill_in = CW'(q_addr) + CW'(1);
            end
            mtp_pkg::KIND_START: begin
               gap_left_in = gap_ticks;
            end
            mtp_pkg::KIND_TICK: begin
               rsp_valid_in = 1'b1;
               if (preamble_pos_ff < pilot_ticks) begin
                  level_in        = preamble_pos_ff[0];
                  seg_in          = mtp_pkg::SEG_PILOT;
                  preamble_pos_in = preamble_pos_ff + mtp_pkg::PILOT_W'(1);
               end else if (gap_left_ff != '0) begin
                  level_in    = 1'b0;
                  seg_in      = mtp_pkg::SEG_GAP;
                  gap_left_in = gap_left_ff - mtp_pkg::GAP_W'(1);
               end else begin
                  seg_in = mtp_pkg::SEG_DATA;
                  if (message_bits == '0 || read_pos_ff >= message_bits) begin
                     // hold the line low
                     level_in    = 1'b0;
                     read_pos_in = '0;
                  end else begin
                     level_in       = cur_bit ^ second_half_ff;
                     second_half_in = !second_half_ff;
                     if (second_half_ff) begin
                        read_pos_in = (read_pos_inc >= message_bits) ? '0 : read_pos_inc;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // prefetch the bit at the next read position
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bit_store[q_addr] <= q_cmd.bit_val;
      end
      rd_data_ff <= bit_store[read_pos_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      seg_ff   <= seg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         preamble_pos_ff <= '0;
         gap_left_ff     <= mtp_pkg::GAP_RESET;
         second_half_ff  <= 1'b0;
         read_pos_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         preamble_pos_ff <= preamble_pos_in;
         gap_left_ff     <= gap_left_in;
         second_half_ff  <= second_half_in;
         read_pos_ff     <= read_pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   `MTP_ASSERT(a_half_in_range, clock, reset, !second_half_ff || (read_pos_ff < message_bits))
   `MTP_ASSERT(a_fill_bound, clock, reset, fill_ff <= CW'(MAX_BITS))
   `MTP_ASSERT_NEXT(a_tick_gives_rsp, clock, reset, tick_pop, rsp_valid_ff)

endmodule

`default_nettype wire

[src/manchester_transmitter_with_pilot_unit.sv]
// ----------------------------------------------------------------------------
// manchester_transmitter_with_pilot_unit
// Loads a message from received characters, then drives pilot preamble, low
// gap and Manchester-coded message bits, one line level per transmit tick.
//
//   channel  direction  tdata (low bit up)                 tuser
//   req_     in         rx_char[7:0]                       action
//   rsp_     out        line_level, 7 zeros                segment[1:0]
//   csr_     in         index 0 pilot_ticks, 1 gap_ticks   -
//
// One request per cycle sustained while rsp_ is not stalled; a tick passes
// through the queue entry and the registered result stage to reach rsp_.
// The rate is set by the tick update in the line driver, with the store read
// prefetched at the next read position. Reset is synchronous; unwritten
// store entries are masked by a fill count, so no clearing pass runs.
// A stalled rsp_ holds ticks in the two-entry queue, then drops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module manchester_transmitter_with_pilot_unit #(
   parameter int MAX_BITS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,   // rx_char[7:0]
   input  wire logic                        req_tuser,   // action
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [7:0]                       rsp_tdata,   // line_level, pad
   output logic [1:0]                       rsp_tuser,   // segment[1:0]
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [mtp_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_BITS + 1);
   localparam int AW = $clog2(MAX_BITS);
   localparam int DW = AW + mtp_pkg::CMD_W;

   logic [mtp_pkg::PILOT_W-1:0] pilot_ff;
   logic [mtp_pkg::GAP_W-1:0]   gap_ff;
   logic                        q_full;
   logic                        q_push;
   logic                        q_pop;
   logic                        q_valid;
   mtp_pkg::cmd_type            push_cmd;
   logic [AW-1:0]               push_addr;
   logic [DW-1:0]               pop_data;
   logic [CW-1:0]               message_bits;
   logic                        line_level;
   logic [1:0]                  segment;

   always_ff @(posedge clock) begin
      if (reset) begin
         pilot_ff <= mtp_pkg::PILOT_RESET;
         gap_ff   <= mtp_pkg::GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mtp_pkg::CSR_PILOT: pilot_ff <= csr_wdata[mtp_pkg::PILOT_W-1:0];
            mtp_pkg::CSR_GAP:   gap_ff   <= csr_wdata[mtp_pkg::GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mtp_front #(
      .MAX_BITS (MAX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .action       (req_tuser),
      .rx_char      (req_tdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd),
      .q_addr       (push_addr),
      .message_bits (message_bits)
   );

   mtp_queue #(
      .DW (DW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_addr, push_cmd}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_data)
   );

   mtp_back #(
      .MAX_BITS (MAX_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pilot_ticks  (pilot_ff),
      .gap_ticks    (gap_ff),
      .message_bits (message_bits),
      .q_valid      (q_valid),
      .q_cmd        (mtp_pkg::cmd_type'(pop_data[mtp_pkg::CMD_W-1:0])),
      .q_addr       (pop_data[DW-1:mtp_pkg::CMD_W]),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .line_level   (line_level),
      .segment      (segment)
   );

   assign rsp_tdata = {7'b0000000, line_level};
   assign rsp_tuser = segment;

endmodule

`default_nettype wire
